FILE: design/tkc_pkg.sv
// ----------------------------------------------------------------------------
// tkc_pkg
// Shared types, codes, constants and character helpers for the keyword
// counter: opcodes, result kinds, controller states and cell control bundles.
// ----------------------------------------------------------------------------
package tkc_pkg;

  // Default sizes
  localparam int WORD_BYTES_DEF     = 32;
  localparam int STOP_ENTRIES_DEF   = 256;
  localparam int TOXIC_ENTRIES_DEF  = 256;
  localparam int UNIQUE_ENTRIES_DEF = 1024;
  localparam int COUNT_BITS_DEF     = 24;

  // Fixed field widths
  localparam int OPCODE_W = 3;
  localparam int BYTE_W   = 8;
  localparam int INDEX_W  = 8;
  localparam int KIND_W   = 2;
  localparam int HITS_W   = 9;
  localparam int TOTAL_W  = 24;
  localparam int UNIQ_W   = 11;

  localparam logic [HITS_W-1:0] HITS_MAX = '1;

  typedef enum logic [OPCODE_W-1:0] {
    OP_TEXT       = 3'd0,
    OP_END        = 3'd1,
    OP_CLEAR      = 3'd2,
    OP_STOP_BYTE  = 3'd3,
    OP_TOXIC_BYTE = 3'd4,
    OP_CLEAR_DICT = 3'd5,
    OP_READ       = 3'd6
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_TOKEN = 2'd0,
    KIND_END   = 2'd1,
    KIND_READ  = 2'd2
  } kind_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_STOP,
    ST_UNIQ,
    ST_TOX,
    ST_READ,
    ST_DONE
  } state_t;

  // Control from the controller to the cell chain
  typedef struct packed {
    logic wr;
    logic fold;
  } chain_ctl_t;

  // Control from the chain to one cell
  typedef struct packed {
    logic wr;
    logic fold;
    logic active;
  } cell_ctl_t;

  function automatic logic [BYTE_W-1:0] to_lower(input logic [BYTE_W-1:0] c);
    logic [BYTE_W-1:0] r;
    r = c;
    if (c >= 8'h41 && c <= 8'h5A) r = c + 8'd32;
    return r;
  endfunction

  function automatic logic is_delim(input logic [BYTE_W-1:0] c);
    return c == 8'h20 || c == 8'h09 || c == 8'h0A || c == 8'h2C || c == 8'h2E ||
           c == 8'h3A || c == 8'h3B || c == 8'h21 || c == 8'h3F || c == 8'h22 ||
           c == 8'h27;
  endfunction

  function automatic logic is_space(input logic [BYTE_W-1:0] c);
    return c == 8'h20 || (c >= 8'h09 && c <= 8'h0D);
  endfunction

  function automatic logic is_alnum(input logic [BYTE_W-1:0] c);
    return (c >= 8'h61 && c <= 8'h7A) || (c >= 8'h30 && c <= 8'h39);
  endfunction

endpackage

FILE: design/tkc_if.sv
// ----------------------------------------------------------------------------
// tkc_req_if / tkc_rsp_if
// Valid/ready channels for request items and result items.
// ----------------------------------------------------------------------------
interface tkc_req_if;
  import tkc_pkg::*;

  logic                valid;
  logic                ready;
  logic [OPCODE_W-1:0] opcode;
  logic [BYTE_W-1:0]   byte_value;
  logic [INDEX_W-1:0]  entry_index;

  modport source(output valid, opcode, byte_value, entry_index, input ready);
  modport sink(input valid, opcode, byte_value, entry_index, output ready);
endinterface

interface tkc_rsp_if;
  import tkc_pkg::*;

  logic               valid;
  logic               ready;
  logic [KIND_W-1:0]  result_kind;
  logic               word_counted;
  logic               new_unique;
  logic [HITS_W-1:0]  toxic_hits;
  logic [TOTAL_W-1:0] total_words;
  logic [UNIQ_W-1:0]  unique_words;
  logic [TOTAL_W-1:0] total_letters;
  logic [TOTAL_W-1:0] total_toxic;
  logic [TOTAL_W-1:0] read_count;
  logic               token_truncated;
  logic               table_full;

  modport source(output valid, result_kind, word_counted, new_unique, toxic_hits,
                 total_words, unique_words, total_letters, total_toxic, read_count,
                 token_truncated, table_full, input ready);
  modport sink(input valid, result_kind, word_counted, new_unique, toxic_hits,
               total_words, unique_words, total_letters, total_toxic, read_count,
               token_truncated, table_full, output ready);
endinterface

FILE: design/text_keyword_counter.sv
// ----------------------------------------------------------------------------
// text_keyword_counter
// Tokenizes text bytes, filters stopwords, tracks unique words and counts
// hits against a toxic word list, with byte-wise dictionary loading.
// ----------------------------------------------------------------------------
// Text and dictionary bytes that do not close a token are taken back to back.
// A finished token walks the stop, unique and toxic tables in turn (a stopword
// ends after the stop table): each table is walked a row per cycle through its
// registered read port. A counter read fetches its hit counter in a read state.
// Results leave through an output register. Reset, clear analysis and clear
// dictionaries sweep the hit counters, one entry a cycle, with no item accepted meanwhile.
// ----------------------------------------------------------------------------
module text_keyword_counter #(
  parameter int WORD_BYTES     = tkc_pkg::WORD_BYTES_DEF,
  parameter int STOP_ENTRIES   = tkc_pkg::STOP_ENTRIES_DEF,
  parameter int TOXIC_ENTRIES  = tkc_pkg::TOXIC_ENTRIES_DEF,
  parameter int UNIQUE_ENTRIES = tkc_pkg::UNIQUE_ENTRIES_DEF,
  parameter int COUNT_BITS     = tkc_pkg::COUNT_BITS_DEF
) (
  input logic       clk,
  input logic       rst,
  tkc_req_if.sink   req,
  tkc_rsp_if.source rsp
);
  import tkc_pkg::*;

  localparam int LEN_W   = $clog2(WORD_BYTES + 1);
  localparam int IDX_W   = $clog2(WORD_BYTES);
  localparam int ROW_W   = WORD_BYTES * BYTE_W;
  localparam int STOP_AW = (STOP_ENTRIES > 1) ? $clog2(STOP_ENTRIES) : 1;
  localparam int TOX_AW  = (TOXIC_ENTRIES > 1) ? $clog2(TOXIC_ENTRIES) : 1;
  localparam int UNIQ_AW = (UNIQUE_ENTRIES > 1) ? $clog2(UNIQUE_ENTRIES) : 1;
  localparam int STOP_UW = $clog2(STOP_ENTRIES + 1);
  localparam int TOX_UW  = $clog2(TOXIC_ENTRIES + 1);
  localparam int UNIQ_UW = $clog2(UNIQUE_ENTRIES + 1);
  localparam int SCAN_A  = (STOP_UW > TOX_UW) ? STOP_UW : TOX_UW;
  localparam int SCAN_W  = (SCAN_A > UNIQ_UW) ? SCAN_A : UNIQ_UW;
  localparam logic [COUNT_BITS-1:0] COUNT_MAX = '1;
  localparam logic [TOX_AW-1:0]     CLR_LAST  = TOX_AW'(TOXIC_ENTRIES - 1);

  state_t state, state_next;

  logic [SCAN_W-1:0]     scan_addr;
  logic                  pend;
  logic [TOX_AW-1:0]     chk_addr;
  logic [TOX_AW-1:0]     clr_addr;
  logic [LEN_W-1:0]      token_length;
  logic                  tok_open;
  logic                  tok_cut;
  logic [LEN_W-1:0]      load_fill;
  logic                  load_target;
  logic [STOP_UW-1:0]    stop_used;
  logic [TOX_UW-1:0]     toxic_used;
  logic [UNIQ_UW-1:0]    unique_used;
  logic [COUNT_BITS-1:0] word_total;
  logic [COUNT_BITS-1:0] letter_total;
  logic [COUNT_BITS-1:0] toxic_total;
  logic                  rd_oor;

  kind_t                 res_kind;
  logic                  res_wc;
  logic                  res_nu;
  logic [HITS_W-1:0]     res_hits;
  logic [COUNT_BITS-1:0] res_rc;
  logic                  res_cut;
  logic                  res_full;

  // decoded control
  logic              accept;
  op_t               op;
  logic [BYTE_W-1:0] bval;
  logic [BYTE_W-1:0] lc;
  logic              delim;
  logic              keep;
  logic              tgt;
  logic [LEN_W-1:0]  fill_eff;
  logic              dict_full;
  logic              dict_byte;
  logic              dict_commit;
  logic [SCAN_W-1:0] cur_used;
  logic              issue;
  logic              hit;
  logic              scan_end;
  logic              out_free;
  logic              tok_done;

  chain_ctl_t        chain_ctl;
  logic              chain_match;
  logic [ROW_W-1:0]  tok_row;
  logic [ROW_W-1:0]  row_sel;
  logic [LEN_W-1:0]  len_sel;

  logic [WORD_BYTES-1:0] lane_mask;
  logic [ROW_W-1:0]      lane_data;
  logic [WORD_BYTES-1:0] stop_mask, tox_mask, uniq_mask;
  logic                  stop_len_we, tox_len_we, uniq_we;
  logic [ROW_W-1:0]      stop_row, tox_row, uniq_row;
  logic [LEN_W-1:0]      stop_len, tox_len, uniq_len;

  logic [COUNT_BITS-1:0] cnt_mem [TOXIC_ENTRIES];
  logic [COUNT_BITS-1:0] cnt_rdata;
  logic [TOX_AW-1:0]     cnt_raddr;
  logic                  cnt_we;
  logic [TOX_AW-1:0]     cnt_waddr;
  logic [COUNT_BITS-1:0] cnt_wdata;

  logic [COUNT_BITS:0]   letter_sum;

  // --------------------------------------------------------------------------
  // Next state
  // --------------------------------------------------------------------------
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (clr_addr == CLR_LAST) state_next = ST_IDLE;
      end
      ST_IDLE: begin
        if (accept) begin
          case (op)
            OP_TEXT: begin
              if (delim && tok_open) begin
                state_next = (token_length == '0) ? ST_DONE : ST_STOP;
              end
            end
            OP_END: begin
              state_next = (tok_open && token_length != '0) ? ST_STOP : ST_DONE;
            end
            OP_CLEAR:      state_next = ST_CLEAR;
            OP_CLEAR_DICT: state_next = ST_CLEAR;
            OP_READ:       state_next = ST_READ;
            default:       state_next = ST_IDLE;
          endcase
        end
      end
      ST_STOP: begin
        if (hit) state_next = ST_DONE;
        else if (scan_end) state_next = ST_UNIQ;
      end
      ST_UNIQ: begin
        if (hit || scan_end) state_next = ST_TOX;
      end
      ST_TOX: begin
        if (scan_end) state_next = ST_DONE;
      end
      ST_READ: state_next = ST_DONE;
      ST_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_CLEAR;
    endcase
  end

  // --------------------------------------------------------------------------
  // Control outputs
  // --------------------------------------------------------------------------
  always_comb begin
    req.ready = (state == ST_IDLE);
    accept    = req.valid && req.ready;
    op        = op_t'(req.opcode);
    bval      = req.byte_value;
    lc        = to_lower(bval);
    delim     = is_delim(bval);
    keep      = !delim && is_alnum(lc);
    out_free  = !rsp.valid || rsp.ready;

    // dictionary loading: a switch of target restarts the partial entry
    tgt       = (op == OP_TOXIC_BYTE);
    fill_eff  = (tgt != load_target) ? '0 : load_fill;
    dict_full = tgt ? (toxic_used >= TOX_UW'(TOXIC_ENTRIES))
                    : (stop_used >= STOP_UW'(STOP_ENTRIES));
    dict_byte   = accept && (op == OP_STOP_BYTE || op == OP_TOXIC_BYTE) && !dict_full;
    dict_commit = dict_byte && is_space(bval) && fill_eff != '0;
    lane_mask   = (dict_byte && !is_space(bval) && fill_eff < LEN_W'(WORD_BYTES))
                  ? (WORD_BYTES'(1) << fill_eff) : '0;
    lane_data   = {WORD_BYTES{bval}};
    stop_mask   = tgt ? '0 : lane_mask;
    tox_mask    = tgt ? lane_mask : '0;
    stop_len_we = dict_commit && !tgt;
    tox_len_we  = dict_commit && tgt;

    case (state)
      ST_STOP: begin
        cur_used = SCAN_W'(stop_used);
        row_sel  = stop_row;
        len_sel  = stop_len;
      end
      ST_UNIQ: begin
        cur_used = SCAN_W'(unique_used);
        row_sel  = uniq_row;
        len_sel  = uniq_len;
      end
      ST_TOX: begin
        cur_used = SCAN_W'(toxic_used);
        row_sel  = tox_row;
        len_sel  = tox_len;
      end
      default: begin
        cur_used = '0;
        row_sel  = tox_row;
        len_sel  = tox_len;
      end
    endcase
    issue    = scan_addr < cur_used;
    hit      = pend && (len_sel == token_length) && chain_match;
    scan_end = !pend && !issue;

    chain_ctl.wr   = accept && (op == OP_TEXT) && keep && token_length < LEN_W'(WORD_BYTES);
    chain_ctl.fold = (state == ST_TOX);

    uniq_we   = (state == ST_UNIQ) && scan_end &&
                (unique_used < UNIQ_UW'(UNIQUE_ENTRIES));
    uniq_mask = uniq_we ? '1 : '0;

    cnt_raddr = (state == ST_IDLE) ? TOX_AW'(req.entry_index) : scan_addr[TOX_AW-1:0];
    cnt_we    = (state == ST_CLEAR) || ((state == ST_TOX) && hit);
    cnt_waddr = (state == ST_CLEAR) ? clr_addr : chk_addr;
    cnt_wdata = (state == ST_CLEAR) ? '0 :
                ((cnt_rdata == COUNT_MAX) ? COUNT_MAX : cnt_rdata + 1'b1);

    // token state is dropped when a finish completes, not by a counter read
    tok_done  = (state_next == ST_DONE) && (state != ST_DONE) && (state != ST_READ);

    letter_sum = {1'b0, letter_total} + (COUNT_BITS + 1)'(token_length);
  end

  // --------------------------------------------------------------------------
  // Cell row and tables
  // --------------------------------------------------------------------------
  tkc_cell_chain #(.WORD_BYTES(WORD_BYTES)) u_chain (
    .clk         (clk),
    .ctl         (chain_ctl),
    .wr_idx      (token_length[IDX_W-1:0]),
    .byte_in     (lc),
    .row         (row_sel),
    .token_length(token_length),
    .match       (chain_match),
    .tok_row     (tok_row)
  );

  tkc_row_store #(.DEPTH(STOP_ENTRIES), .WORD_BYTES(WORD_BYTES)) u_stop (
    .clk      (clk),
    .wmask    (stop_mask),
    .waddr    (stop_used[STOP_AW-1:0]),
    .wdata    (lane_data),
    .len_we   (stop_len_we),
    .len_wdata(fill_eff),
    .raddr    (scan_addr[STOP_AW-1:0]),
    .rdata    (stop_row),
    .rlen     (stop_len)
  );

  tkc_row_store #(.DEPTH(TOXIC_ENTRIES), .WORD_BYTES(WORD_BYTES)) u_toxic (
    .clk      (clk),
    .wmask    (tox_mask),
    .waddr    (toxic_used[TOX_AW-1:0]),
    .wdata    (lane_data),
    .len_we   (tox_len_we),
    .len_wdata(fill_eff),
    .raddr    (scan_addr[TOX_AW-1:0]),
    .rdata    (tox_row),
    .rlen     (tox_len)
  );

  tkc_row_store #(.DEPTH(UNIQUE_ENTRIES), .WORD_BYTES(WORD_BYTES)) u_unique (
    .clk      (clk),
    .wmask    (uniq_mask),
    .waddr    (unique_used[UNIQ_AW-1:0]),
    .wdata    (tok_row),
    .len_we   (uniq_we),
    .len_wdata(token_length),
    .raddr    (scan_addr[UNIQ_AW-1:0]),
    .rdata    (uniq_row),
    .rlen     (uniq_len)
  );

  // hit counters
  always_ff @(posedge clk) begin
    if (cnt_we) cnt_mem[cnt_waddr] <= cnt_wdata;
    cnt_rdata <= cnt_mem[cnt_raddr];
  end

  // --------------------------------------------------------------------------
  // Control and totals
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      clr_addr     <= '0;
      scan_addr    <= '0;
      chk_addr     <= '0;
      pend         <= 1'b0;
      token_length <= '0;
      tok_open     <= 1'b0;
      tok_cut      <= 1'b0;
      load_fill    <= '0;
      load_target  <= 1'b0;
      stop_used    <= '0;
      toxic_used   <= '0;
      unique_used  <= '0;
      word_total   <= '0;
      letter_total <= '0;
      toxic_total  <= '0;
      rsp.valid    <= 1'b0;
    end else begin
      state <= state_next;

      if (state == ST_CLEAR) begin
        clr_addr <= (clr_addr == CLR_LAST) ? '0 : clr_addr + 1'b1;
      end

      // walk a table: issue one row a cycle, check it the next
      if (state_next != state) begin
        scan_addr <= '0;
        pend      <= 1'b0;
      end else if (state == ST_STOP || state == ST_UNIQ || state == ST_TOX) begin
        if (issue) begin
          scan_addr <= scan_addr + 1'b1;
          chk_addr  <= scan_addr[TOX_AW-1:0];
        end
        pend <= issue;
      end

      if (accept) begin
        case (op)
          OP_TEXT: begin
            if (!delim) begin
              tok_open <= 1'b1;
              if (keep) begin
                if (token_length < LEN_W'(WORD_BYTES)) token_length <= token_length + 1'b1;
                else tok_cut <= 1'b1;
              end
            end
          end
          OP_CLEAR: begin
            word_total   <= '0;
            letter_total <= '0;
            toxic_total  <= '0;
            unique_used  <= '0;
            token_length <= '0;
            tok_open     <= 1'b0;
            tok_cut      <= 1'b0;
          end
          OP_STOP_BYTE, OP_TOXIC_BYTE: begin
            load_target <= tgt;
            if (dict_full || is_space(bval)) load_fill <= '0;
            else if (fill_eff < LEN_W'(WORD_BYTES)) load_fill <= fill_eff + 1'b1;
            else load_fill <= fill_eff;
            if (stop_len_we) stop_used <= stop_used + 1'b1;
            if (tox_len_we) toxic_used <= toxic_used + 1'b1;
          end
          OP_CLEAR_DICT: begin
            stop_used  <= '0;
            toxic_used <= '0;
            load_fill  <= '0;
          end
          default: begin
          end
        endcase
      end

      if (state == ST_STOP && !hit && scan_end) begin
        word_total   <= (word_total == COUNT_MAX) ? COUNT_MAX : word_total + 1'b1;
        letter_total <= letter_sum[COUNT_BITS] ? COUNT_MAX : letter_sum[COUNT_BITS-1:0];
      end
      if (uniq_we) unique_used <= unique_used + 1'b1;
      if (state == ST_TOX && hit) begin
        toxic_total <= (toxic_total == COUNT_MAX) ? COUNT_MAX : toxic_total + 1'b1;
      end

      if (tok_done) begin
        token_length <= '0;
        tok_open     <= 1'b0;
        tok_cut      <= 1'b0;
      end

      if (state == ST_DONE && out_free) rsp.valid <= 1'b1;
      else if (rsp.ready) rsp.valid <= 1'b0;
    end
  end

  // --------------------------------------------------------------------------
  // Result fields
  // --------------------------------------------------------------------------
  always_ff @(posedge clk) begin
    if (accept) begin
      res_wc   <= 1'b0;
      res_nu   <= 1'b0;
      res_hits <= '0;
      res_rc   <= '0;
      res_full <= 1'b0;
      res_cut  <= tok_open && tok_cut;
      rd_oor   <= int'(req.entry_index) >= TOXIC_ENTRIES;
      case (op)
        OP_END:  res_kind <= KIND_END;
        OP_READ: begin
          res_kind <= KIND_READ;
          res_cut  <= 1'b0;
        end
        default: res_kind <= KIND_TOKEN;
      endcase
    end
    if (state == ST_STOP && !hit && scan_end) res_wc <= 1'b1;
    if (uniq_we) res_nu <= 1'b1;
    if (state == ST_UNIQ && scan_end && !uniq_we) res_full <= 1'b1;
    if (state == ST_TOX && hit && res_hits != HITS_MAX) res_hits <= res_hits + 1'b1;
    if (state == ST_READ) res_rc <= rd_oor ? '0 : cnt_rdata;

    if (state == ST_DONE && out_free) begin
      rsp.result_kind     <= res_kind;
      rsp.word_counted    <= res_wc;
      rsp.new_unique      <= res_nu;
      rsp.toxic_hits      <= res_hits;
      rsp.total_words     <= TOTAL_W'(word_total);
      rsp.unique_words    <= UNIQ_W'(unique_used);
      rsp.total_letters   <= TOTAL_W'(letter_total);
      rsp.total_toxic     <= TOTAL_W'(toxic_total);
      rsp.read_count      <= TOTAL_W'(res_rc);
      rsp.token_truncated <= res_cut;
      rsp.table_full      <= res_full;
    end
  end

  // --------------------------------------------------------------------------
  // Assertions
  // --------------------------------------------------------------------------
  a_len_bound: assert property (@(posedge clk) disable iff (rst)
    token_length <= LEN_W'(WORD_BYTES))
    else $error("token length beyond word size");

  a_uniq_bound: assert property (@(posedge clk) disable iff (rst)
    unique_used <= UNIQ_UW'(UNIQUE_ENTRIES))
    else $error("unique table overfilled");

  a_cnt_write: assert property (@(posedge clk) disable iff (rst)
    cnt_we |-> (state == ST_CLEAR || state == ST_TOX))
    else $error("hit counter written outside clear or toxic walk");

  a_read_done: assert property (@(posedge clk) disable iff (rst)
    state == ST_READ |=> state == ST_DONE)
    else $error("counter read did not finish");

  a_tok_cleared: assert property (@(posedge clk) disable iff (rst)
    (state == ST_TOX && scan_end) |=> (token_length == '0 && !tok_open))
    else $error("token state kept after finish");

endmodule

FILE: design/tkc_cell.sv
// ----------------------------------------------------------------------------
// tkc_cell
// One byte of the token buffer. Compares its byte with the matching byte of a
// table row and passes the running match on to the next cell.
// ----------------------------------------------------------------------------
module tkc_cell (
  input  logic                    clk,
  input  tkc_pkg::cell_ctl_t      ctl,
  input  logic [tkc_pkg::BYTE_W-1:0] byte_in,
  input  logic [tkc_pkg::BYTE_W-1:0] row_byte,
  input  logic                    match_in,
  output logic                    match_out,
  output logic [tkc_pkg::BYTE_W-1:0] tok
);
  import tkc_pkg::*;

  logic eq;

  always_ff @(posedge clk) begin
    if (ctl.wr) tok <= byte_in;
  end

  // toxic entries are folded to lowercase, the token already is
  assign eq = ctl.fold ? (to_lower(row_byte) == tok) : (row_byte == tok);
  assign match_out = match_in & (~ctl.active | eq);

endmodule

FILE: design/tkc_cell_chain.sv
// ----------------------------------------------------------------------------
// tkc_cell_chain
// Row of token cells. Loads kept bytes at the current length and ripples a
// match flag across the active cells against one table row per cycle.
// ----------------------------------------------------------------------------
module tkc_cell_chain #(
  parameter int WORD_BYTES = tkc_pkg::WORD_BYTES_DEF,
  localparam int LEN_W     = $clog2(WORD_BYTES + 1),
  localparam int IDX_W     = $clog2(WORD_BYTES)
) (
  input  logic                               clk,
  input  tkc_pkg::chain_ctl_t                ctl,
  input  logic [IDX_W-1:0]                   wr_idx,
  input  logic [tkc_pkg::BYTE_W-1:0]         byte_in,
  input  logic [WORD_BYTES*tkc_pkg::BYTE_W-1:0] row,
  input  logic [LEN_W-1:0]                   token_length,
  output logic                               match,
  output logic [WORD_BYTES*tkc_pkg::BYTE_W-1:0] tok_row
);
  import tkc_pkg::*;

  logic [WORD_BYTES:0] link;

  assign link[0] = 1'b1;
  assign match   = link[WORD_BYTES];

  for (genvar i = 0; i < WORD_BYTES; i++) begin : g_cell
    cell_ctl_t cctl;

    assign cctl.wr     = ctl.wr && (wr_idx == IDX_W'(i));
    assign cctl.fold   = ctl.fold;
    assign cctl.active = LEN_W'(i) < token_length;

    tkc_cell u_cell (
      .clk      (clk),
      .ctl      (cctl),
      .byte_in  (byte_in),
      .row_byte (row[i*BYTE_W +: BYTE_W]),
      .match_in (link[i]),
      .match_out(link[i+1]),
      .tok      (tok_row[i*BYTE_W +: BYTE_W])
    );
  end

endmodule

FILE: design/tkc_row_store.sv
// ----------------------------------------------------------------------------
// tkc_row_store
// Word table: one row of WORD_BYTES bytes per entry with byte-lane writes,
// plus a length per entry. Reads are registered.
// ----------------------------------------------------------------------------
module tkc_row_store #(
  parameter int DEPTH      = tkc_pkg::STOP_ENTRIES_DEF,
  parameter int WORD_BYTES = tkc_pkg::WORD_BYTES_DEF,
  localparam int AW        = (DEPTH > 1) ? $clog2(DEPTH) : 1,
  localparam int LEN_W     = $clog2(WORD_BYTES + 1),
  localparam int ROW_W     = WORD_BYTES * tkc_pkg::BYTE_W
) (
  input  logic                  clk,
  input  logic [WORD_BYTES-1:0] wmask,
  input  logic [AW-1:0]         waddr,
  input  logic [ROW_W-1:0]      wdata,
  input  logic                  len_we,
  input  logic [LEN_W-1:0]      len_wdata,
  input  logic [AW-1:0]         raddr,
  output logic [ROW_W-1:0]      rdata,
  output logic [LEN_W-1:0]      rlen
);
  import tkc_pkg::*;

  logic [ROW_W-1:0] mem [DEPTH];
  logic [LEN_W-1:0] len_mem [DEPTH];

  always_ff @(posedge clk) begin
    for (int i = 0; i < WORD_BYTES; i++) begin
      if (wmask[i]) mem[waddr][i*BYTE_W +: BYTE_W] <= wdata[i*BYTE_W +: BYTE_W];
    end
    if (len_we) len_mem[waddr] <= len_wdata;
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
    rlen  <= len_mem[raddr];
  end

endmodule

FILE: tb/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for text_keyword_counter. A queue of request items
// drives the block through a valid/ready channel. Each accepted item updates
// a local model of the tokenizer, dictionaries and totals, and every result
// item is checked against the oldest expected result.
// ----------------------------------------------------------------------------
module tb;
  import tkc_pkg::*;

  localparam int WB = WORD_BYTES_DEF;
  localparam int NSTOP = STOP_ENTRIES_DEF;
  localparam int NTOX = TOXIC_ENTRIES_DEF;
  localparam int NUNIQ = UNIQUE_ENTRIES_DEF;
  localparam logic [TOTAL_W-1:0] CNT_MAX = '1;
  localparam logic [OPCODE_W-1:0] OP_IGNORED = 3'd7;
  localparam int CYCLE_LIMIT = 20000000;

  typedef struct {
    logic [OPCODE_W-1:0] op;
    logic [BYTE_W-1:0]   b;
    logic [INDEX_W-1:0]  idx;
    bit                  hold;
  } req_item_t;

  typedef struct packed {
    kind_t              kind;
    logic               counted;
    logic               fresh;
    logic [HITS_W-1:0]  hits;
    logic [TOTAL_W-1:0] words;
    logic [UNIQ_W-1:0]  uniq;
    logic [TOTAL_W-1:0] letters;
    logic [TOTAL_W-1:0] toxic;
    logic [TOTAL_W-1:0] rdcnt;
    logic               cut;
    logic               full;
  } tally_t;

  logic clk = 0;
  logic rst = 1;
  always #6 clk = ~clk;

  tkc_req_if req();
  tkc_rsp_if rsp();

  text_keyword_counter uut (.clk(clk), .rst(rst), .req(req), .rsp(rsp));

  req_item_t pending_items[$];
  tally_t    expected_tallies[$];
  int        phase = 0;
  bit        stim_done = 0;
  bit        accepted = 0;
  int        mismatches = 0;
  int        results_seen = 0;
  int        items_sent = 0;
  int        cycles = 0;
  int        kind_seen[3];

  // Tokenizer and dictionary state
  logic [7:0]         stop_mem[NSTOP][WB];
  int                 stop_len[NSTOP];
  int                 stop_cnt;
  logic [7:0]         tox_mem[NTOX][WB];
  int                 tox_len[NTOX];
  int                 tox_cnt;
  logic [TOTAL_W-1:0] tox_count[NTOX];
  logic [7:0]         uniq_mem[NUNIQ][WB];
  int                 uniq_len[NUNIQ];
  int                 uniq_cnt;
  logic [7:0]         tok[WB];
  int                 tok_len;
  bit                 tok_open, tok_cut;
  int                 fill;
  bit                 fill_tox;
  logic [TOTAL_W-1:0] word_sum, letter_sum, toxic_sum;

  function automatic logic [TOTAL_W-1:0] sat_inc(logic [TOTAL_W-1:0] a, int n);
    longint s;
    s = longint'(a) + n;
    return (s > CNT_MAX) ? CNT_MAX : s[TOTAL_W-1:0];
  endfunction

  function automatic logic [7:0] fold(logic [7:0] c);
    return (c >= "A" && c <= "Z") ? c + 8'd32 : c;
  endfunction

  function automatic bit splits_token(logic [7:0] c);
    return c inside {" ", 8'h09, 8'h0A, ",", ".", ":", ";", "!", "?", 8'h22, 8'h27};
  endfunction

  function automatic tally_t totals(kind_t k);
    tally_t t;
    t = '0;
    t.kind = k;
    t.words = word_sum;
    t.uniq = UNIQ_W'(uniq_cnt);
    t.letters = letter_sum;
    t.toxic = toxic_sum;
    return t;
  endfunction

  function void close_token(kind_t k);
    tally_t t;
    bit stop, known, same;
    int i, j;
    t = totals(k);
    stop = 0;
    known = 0;
    if (tok_len > 0) begin
      for (i = 0; i < stop_cnt && !stop; i++) begin
        same = (stop_len[i] == tok_len);
        for (j = 0; j < tok_len && same; j++) same = (stop_mem[i][j] == tok[j]);
        stop = same;
      end
      if (!stop) begin
        t.counted = 1;
        word_sum = sat_inc(word_sum, 1);
        letter_sum = sat_inc(letter_sum, tok_len);
        for (i = 0; i < uniq_cnt && !known; i++) begin
          same = (uniq_len[i] == tok_len);
          for (j = 0; j < tok_len && same; j++) same = (uniq_mem[i][j] == tok[j]);
          known = same;
        end
        if (!known) begin
          if (uniq_cnt < NUNIQ) begin
            for (j = 0; j < tok_len; j++) uniq_mem[uniq_cnt][j] = tok[j];
            uniq_len[uniq_cnt] = tok_len;
            uniq_cnt++;
            t.fresh = 1;
          end else t.full = 1;
        end
        for (i = 0; i < tox_cnt; i++) begin
          same = (tox_len[i] == tok_len);
          for (j = 0; j < tok_len && same; j++) same = (fold(tox_mem[i][j]) == tok[j]);
          if (same) begin
            tox_count[i] = sat_inc(tox_count[i], 1);
            toxic_sum = sat_inc(toxic_sum, 1);
            if (t.hits != HITS_MAX) t.hits++;
          end
        end
      end
    end
    t.words = word_sum;
    t.uniq = UNIQ_W'(uniq_cnt);
    t.letters = letter_sum;
    t.toxic = toxic_sum;
    t.cut = tok_cut;
    expected_tallies.push_back(t);
    tok_len = 0;
    tok_open = 0;
    tok_cut = 0;
  endfunction

  function void load_dict_byte(bit to_tox, logic [7:0] c);
    int cap_full;
    if (to_tox != fill_tox) begin
      fill = 0;
      fill_tox = to_tox;
    end
    cap_full = to_tox ? (tox_cnt >= NTOX) : (stop_cnt >= NSTOP);
    if (cap_full) begin
      fill = 0;
      return;
    end
    if (c == " " || (c >= 8'h09 && c <= 8'h0D)) begin
      if (fill > 0) begin
        if (to_tox) tox_len[tox_cnt++] = fill;
        else stop_len[stop_cnt++] = fill;
      end
      fill = 0;
    end else if (fill < WB) begin
      if (to_tox) tox_mem[tox_cnt][fill] = c;
      else stop_mem[stop_cnt][fill] = c;
      fill++;
    end
  endfunction

  function void predict(req_item_t it);
    tally_t t;
    logic [7:0] c;
    case (it.op)
      OP_TEXT: begin
        if (splits_token(it.b)) begin
          if (tok_open) close_token(KIND_TOKEN);
        end else begin
          tok_open = 1;
          c = fold(it.b);
          if ((c >= "a" && c <= "z") || (c >= "0" && c <= "9")) begin
            if (tok_len < WB) tok[tok_len++] = c;
            else tok_cut = 1;
          end
        end
      end
      OP_END: begin
        if (tok_open) close_token(KIND_END);
        else expected_tallies.push_back(totals(KIND_END));
      end
      OP_CLEAR: begin
        word_sum = 0;
        letter_sum = 0;
        toxic_sum = 0;
        uniq_cnt = 0;
        foreach (tox_count[i]) tox_count[i] = 0;
        tok_len = 0;
        tok_open = 0;
        tok_cut = 0;
      end
      OP_STOP_BYTE: load_dict_byte(0, it.b);
      OP_TOXIC_BYTE: load_dict_byte(1, it.b);
      OP_CLEAR_DICT: begin
        stop_cnt = 0;
        tox_cnt = 0;
        fill = 0;
        foreach (tox_count[i]) tox_count[i] = 0;
      end
      OP_READ: begin
        t = totals(KIND_READ);
        t.rdcnt = (it.idx < NTOX) ? tox_count[it.idx] : '0;
        expected_tallies.push_back(t);
      end
      default: ;
    endcase
  endfunction

  // Accept items, check results, bound the run
  always @(posedge clk) begin
    tally_t got, want;
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d results pending", cycles,
               expected_tallies.size());
      $display("Regression FAIL");
      $finish;
    end
    accepted <= !rst && req.valid && req.ready;
    if (!rst && req.valid && req.ready) begin
      predict('{req.opcode, req.byte_value, req.entry_index, 1'b0});
      items_sent <= items_sent + 1;
    end
    if (!rst && rsp.valid && rsp.ready) begin
      got = '{kind_t'(rsp.result_kind), rsp.word_counted, rsp.new_unique, rsp.toxic_hits,
              rsp.total_words, rsp.unique_words, rsp.total_letters, rsp.total_toxic,
              rsp.read_count, rsp.token_truncated, rsp.table_full};
      results_seen <= results_seen + 1;
      if (got.kind <= KIND_READ) kind_seen[got.kind]++;
      if (expected_tallies.size() == 0) begin
        mismatches <= mismatches + 1;
        if (mismatches < 10) $display("Unexpected result %p", got);
      end else begin
        want = expected_tallies.pop_front();
        if (got !== want) begin
          mismatches <= mismatches + 1;
          if (mismatches < 10) $display("Mismatch\n  exp %p\n  got %p", want, got);
        end
      end
    end
  end

  // Present items and stall the result channel at the falling edge
  always @(negedge clk) begin
    int idle_pct, stall_pct;
    idle_pct = (phase == 0) ? 34 : (phase == 1) ? 47 : 0;
    stall_pct = (phase == 0) ? 47 : (phase == 1) ? 34 : 0;
    if (rst) begin
      req.valid <= 0;
      req.opcode <= OP_TEXT;
      req.byte_value <= 0;
      req.entry_index <= 0;
      rsp.ready <= 0;
    end else begin
      rsp.ready <= ($urandom_range(99) >= stall_pct);
      if (!req.valid || accepted) begin
        if (pending_items.size() > 0 && $urandom_range(99) >= idle_pct &&
            (!pending_items[0].hold || expected_tallies.size() == 0)) begin
          req.valid <= 1;
          req.opcode <= pending_items[0].op;
          req.byte_value <= pending_items[0].b;
          req.entry_index <= pending_items[0].idx;
          void'(pending_items.pop_front());
        end else req.valid <= 0;
      end
    end
  end

  function void push(logic [2:0] op, logic [7:0] b = 0, logic [7:0] idx = 0, bit hold = 0);
    pending_items.push_back('{op, b, idx, hold});
  endfunction

  function void push_text(string s);
    foreach (s[i]) push(OP_TEXT, s[i]);
  endfunction

  function void push_dict(logic [2:0] op, string s);
    foreach (s[i]) push(op, s[i]);
  endfunction

  function automatic string rand_word(int n);
    string pool, s;
    pool = "abcdeABCDE01";
    s = "";
    repeat (n) s = {s, string'(pool[$urandom_range(pool.len() - 1)])};
    return s;
  endfunction

  function void fill_random(int n);
    string seps;
    int r, start;
    seps = {" ", "\t", "\n", ",.:;!?", 8'h22, 8'h27};
    start = pending_items.size();
    while (pending_items.size() - start < n) begin
      r = $urandom_range(999);
      if (r < 760) begin
        push_text($urandom_range(19) == 0 ? rand_word($urandom_range(33, 40))
                                          : rand_word($urandom_range(1, 4)));
        if ($urandom_range(9) == 0) push(OP_TEXT, 8'($urandom));
        push(OP_TEXT, seps[$urandom_range(seps.len() - 1)]);
        if ($urandom_range(7) == 0) push(OP_TEXT, seps[$urandom_range(seps.len() - 1)]);
      end else if (r < 800) push(OP_END);
      else if (r < 840) push(OP_READ, 8'($urandom),
                             8'($urandom_range(3) == 0 ? $urandom : $urandom_range(15)));
      else if (r < 880) push(OP_TEXT, 8'($urandom));
      else if (r < 890) push(OP_IGNORED, 8'($urandom), 8'($urandom));
      else if (r < 940) push_dict(OP_TOXIC_BYTE, {rand_word($urandom_range(1, 3)), " "});
      else if (r < 970) push_dict(OP_STOP_BYTE, {rand_word($urandom_range(1, 3)), "\n"});
      else if (r < 985) push(3'($urandom_range(OP_STOP_BYTE, OP_TOXIC_BYTE)), 8'($urandom));
      else if (r < 995) push(OP_CLEAR);
      else push(OP_CLEAR_DICT);
    end
  endfunction

  initial begin
    int i, total;
    stop_cnt = 0; tox_cnt = 0; uniq_cnt = 0; tok_len = 0; tok_open = 0; tok_cut = 0;
    fill = 0; fill_tox = 0; word_sum = 0; letter_sum = 0; toxic_sum = 0;
    foreach (tox_count[k]) tox_count[k] = 0;

    // Directed: dictionaries, case folding, dropped bytes, empty and long tokens
    push_dict(OP_STOP_BYTE, "the a\t");
    push_dict(OP_TOXIC_BYTE, "Bad ba");
    push_dict(OP_STOP_BYTE, "x ");               // switch abandons partial "ba"
    push_text("The BAD b-a-d,, %% ");
    push_text({"A", 8'hFF, 8'h00, "9z"});
    push(OP_END);
    push(OP_END);
    push(OP_READ, 0, 0);
    push(OP_READ, 0, 8'hFF);
    push(OP_IGNORED, 8'hFF, 8'hFF);
    push_text("abcdefghijklmnopqrstuvwxyz0123456789Q.");
    push_dict(OP_TOXIC_BYTE, "ABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789 ");
    push_text("abcdefghijklmnopqrstuvwxyz012345?");
    push(OP_READ, 0, 1);
    push(OP_CLEAR);
    push(OP_END);
    push(OP_CLEAR_DICT, 0, 0, 1);

    // Toxic list filled with one word, then more ignored; stop list full
    for (i = 0; i < NTOX + 2; i++) push_dict(OP_TOXIC_BYTE, "Zz ");
    for (i = 0; i < NSTOP + 2; i++) push_dict(OP_STOP_BYTE, (i < NSTOP) ? "q " : "zz ");
    push_text("zz q zz;");
    push(OP_READ, 0, 8'd255);
    push(OP_CLEAR_DICT);
    push(OP_CLEAR, 0, 0, 1);

    total = 1550;
    fill_random(total - pending_items.size());
    push(OP_END);

    repeat (5) @(posedge clk);
    rst <= 0;
    total = pending_items.size();
    while (pending_items.size() > 0) begin
      @(posedge clk);
      phase <= (pending_items.size() > 2 * total / 3) ? 0 :
               (pending_items.size() > total / 3) ? 1 : 2;
    end
    while (req.valid || expected_tallies.size() > 0) @(posedge clk);
    repeat (3000) @(posedge clk);
    $display("Sent %0d items, checked %0d results (%0d token, %0d end, %0d read)",
             items_sent, results_seen, kind_seen[0], kind_seen[1], kind_seen[2]);
    $display("Final totals: %0d words, %0d unique, %0d toxic hits; %0d mismatches",
             word_sum, uniq_cnt, toxic_sum, mismatches);
    if (mismatches == 0 && expected_tallies.size() == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
